[rtl/ebb_pkg.sv]
// Shared constants for the edge-normalized box blur.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package ebb_pkg;

    localparam int DEF_MAX_LINE  = 1024;
    localparam int DEF_MAX_LINES = 1024;
    localparam int WINDOW        = 4;
    localparam int HALF_WIN      = WINDOW / 2;
    localparam int TAPS          = WINDOW * WINDOW;

    localparam int VAL_W     = 16;
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 1;
    localparam int OUT_IDX_W = 10;
    localparam int SUM_W     = VAL_W + $clog2(TAPS);
    localparam int CNT_W     = $clog2(TAPS + 1);
    localparam int STEP_W    = $clog2(TAPS + 1);
    localparam int DIVB_W    = $clog2(SUM_W);
    localparam int Q_DEPTH   = 4;
    localparam int MAX_JOBS  = 4;

    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(1024);

    localparam logic [CFG_IDX_W-1:0] CFG_NUM_LINES   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_LENGTH = 1'b1;

endpackage

[rtl/ebb_queue.sv]
// Four-entry job queue between the front and the back of the box blur.
// Depends on ebb_pkg.
`timescale 1ns / 1ps

module ebb_queue
    import ebb_pkg::*;
#(
    parameter int W = 8
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] din,
    input  logic         pop,
    output logic [W-1:0] dout,
    output logic         empty,
    output logic         full
);

    localparam int PTR_W = $clog2(Q_DEPTH);

    logic [W-1:0]       entry_reg [Q_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [PTR_W:0]     fill_reg, fill_next;

    assign empty = (fill_reg == '0);
    assign full  = (fill_reg == (PTR_W+1)'(Q_DEPTH));
    assign dout  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        fill_next = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            fill_reg <= fill_next;
        end
    end

endmodule

[rtl/ebb_front.sv]
// Front of the box blur: configuration, raster counters, store writes and job issue.
// Depends on ebb_pkg.
`timescale 1ns / 1ps

module ebb_front
    import ebb_pkg::*;
#(
    parameter int MAX_LINE  = DEF_MAX_LINE,
    parameter int MAX_LINES = DEF_MAX_LINES,
    parameter int LW        = $clog2(MAX_LINES + 1),
    parameter int PW        = $clog2(MAX_LINE + 1),
    parameter int AW        = $clog2(WINDOW * MAX_LINE),
    parameter int JOB_W     = LW + PW + 2
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [VAL_W-1:0]     sample_value,
    input  logic                 q_empty,
    input  logic                 q_full,
    output logic                 q_push,
    output logic [JOB_W-1:0]     q_din,
    input  logic                 back_busy,
    output logic [LW-1:0]        nl,
    output logic [PW-1:0]        ll,
    output logic                 wr_en,
    output logic [AW-1:0]        wr_addr,
    output logic [VAL_W-1:0]     wr_data
);

    typedef struct packed {
        logic [LW-1:0] line;
        logic [PW-1:0] pos;
        logic          last;
        logic          fdone;
    } job_t;

    logic [CFG_W-1:0]    nl_raw_reg, ll_raw_reg;
    logic [LW-1:0]       line_reg, jl_reg;
    logic [PW-1:0]       pos_reg, jp_reg;
    logic [MAX_JOBS-1:0] mask_reg, mask_next, mask_new, sel_bit;
    logic [1:0]          sel;
    logic                idle, accept, line_end, last_line;
    logic [LW:0]         line_x;
    job_t                job;

    always_comb
    begin
        if (nl_raw_reg == '0)
            nl = LW'(1);
        else if (int'(nl_raw_reg) > MAX_LINES)
            nl = LW'(MAX_LINES);
        else
            nl = LW'(nl_raw_reg);
        if (ll_raw_reg == '0)
            ll = PW'(1);
        else if (int'(ll_raw_reg) > MAX_LINE)
            ll = PW'(MAX_LINE);
        else
            ll = PW'(ll_raw_reg);
    end

    assign idle     = (mask_reg == '0) && q_empty && !back_busy;
    assign in_stall = !idle;
    assign accept   = in_valid && idle;

    assign line_end  = (pos_reg == ll - PW'(1));
    assign last_line = (line_reg == nl - LW'(1));
    assign line_x    = {1'b0, line_reg};

    assign wr_en   = accept;
    assign wr_data = sample_value;
    assign wr_addr = AW'(int'(line_x[1:0]) * MAX_LINE) + AW'(pos_reg);

    always_comb
    begin
        mask_new[0] = (line_reg != '0) && (pos_reg != '0);
        mask_new[1] = (line_reg != '0) && line_end;
        mask_new[2] = last_line && (pos_reg != '0);
        mask_new[3] = last_line && line_end;
    end

    // pick the lowest pending job
    always_comb
    begin
        if (mask_reg[0])
            sel = 2'd0;
        else if (mask_reg[1])
            sel = 2'd1;
        else if (mask_reg[2])
            sel = 2'd2;
        else
            sel = 2'd3;
        sel_bit = MAX_JOBS'(1) << sel;
    end

    always_comb
    begin
        job.line  = sel[1] ? jl_reg : jl_reg - LW'(1);
        job.pos   = sel[0] ? jp_reg : jp_reg - PW'(1);
        job.last  = ((mask_reg & ~sel_bit) == '0);
        job.fdone = (job.line == nl - LW'(1)) && (job.pos == ll - PW'(1));
    end

    assign q_push = (mask_reg != '0) && !q_full;
    assign q_din  = job;

    always_comb
    begin
        mask_next = mask_reg;
        if (q_push)
            mask_next = mask_reg & ~sel_bit;
        if (accept)
            mask_next = mask_new;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nl_raw_reg <= CFG_RESET;
            ll_raw_reg <= CFG_RESET;
            line_reg   <= '0;
            pos_reg    <= '0;
            mask_reg   <= '0;
            jl_reg     <= '0;
            jp_reg     <= '0;
        end
        else
        begin
            mask_reg <= mask_next;
            if (cfg_we)
            begin
                if (cfg_index == CFG_NUM_LINES)
                    nl_raw_reg <= cfg_data;
                else
                    ll_raw_reg <= cfg_data;
                line_reg <= '0;
                pos_reg  <= '0;
            end
            else if (accept)
            begin
                jl_reg <= line_reg;
                jp_reg <= pos_reg;
                if (line_end)
                begin
                    pos_reg  <= '0;
                    line_reg <= last_line ? '0 : line_reg + LW'(1);
                end
                else
                begin
                    pos_reg <= pos_reg + PW'(1);
                end
            end
        end
    end

endmodule

[rtl/ebb_back.sv]
// Back of the box blur: line store, 16-tap gather, serial divide, output register.
// Depends on ebb_pkg.
`timescale 1ns / 1ps

module ebb_back
    import ebb_pkg::*;
#(
    parameter int MAX_LINE  = DEF_MAX_LINE,
    parameter int MAX_LINES = DEF_MAX_LINES,
    parameter int LW        = $clog2(MAX_LINES + 1),
    parameter int PW        = $clog2(MAX_LINE + 1),
    parameter int AW        = $clog2(WINDOW * MAX_LINE),
    parameter int JOB_W     = LW + PW + 2
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_empty,
    input  logic [JOB_W-1:0]     q_dout,
    output logic                 q_pop,
    input  logic [LW-1:0]        nl,
    input  logic [PW-1:0]        ll,
    input  logic                 wr_en,
    input  logic [AW-1:0]        wr_addr,
    input  logic [VAL_W-1:0]     wr_data,
    output logic                 busy,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [VAL_W-1:0]     blurred_value,
    output logic [OUT_IDX_W-1:0] out_line,
    output logic [OUT_IDX_W-1:0] out_position,
    output logic                 last_of_run,
    output logic                 frame_done
);

    typedef struct packed {
        logic [LW-1:0] line;
        logic [PW-1:0] pos;
        logic          last;
        logic          fdone;
    } job_t;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    logic [VAL_W-1:0]  mem [WINDOW * MAX_LINE];

    logic [1:0]        state_reg;
    job_t              job_reg;
    logic [STEP_W-1:0] step_reg;
    logic [SUM_W-1:0]  acc_reg, acc_next, quo_reg;
    logic [CNT_W-1:0]  cnt_reg, cnt_next, divisor;
    logic [VAL_W-1:0]  rd_data_reg;
    logic              rd_v_reg;
    logic [CNT_W:0]    rem_reg, rem_shift;
    logic [DIVB_W-1:0] bit_reg;
    logic              rem_ge;

    logic [LW:0]       t_l, r_l;
    logic [PW:0]       t_p, r_p;
    logic              tap_v;
    logic [AW-1:0]     rd_addr;

    logic [VAL_W-1:0]  val_reg;

    assign busy  = (state_reg != ST_IDLE);
    assign q_pop = (state_reg == ST_IDLE) && !q_empty;

    // tap offsets come from the step count: high bits line, low bits position
    always_comb
    begin
        t_l   = {1'b0, job_reg.line} + (LW+1)'(step_reg[3:2]);
        t_p   = {1'b0, job_reg.pos} + (PW+1)'(step_reg[1:0]);
        r_l   = t_l - (LW+1)'(HALF_WIN);
        r_p   = t_p - (PW+1)'(HALF_WIN);
        tap_v = (t_l >= (LW+1)'(HALF_WIN)) && (r_l < {1'b0, nl})
             && (t_p >= (PW+1)'(HALF_WIN)) && (r_p < {1'b0, ll})
             && (state_reg == ST_READ) && (step_reg < STEP_W'(TAPS));
        rd_addr = AW'(int'(r_l[1:0]) * MAX_LINE) + AW'(r_p);
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_data_reg <= mem[rd_addr];
    end

    always_comb
    begin
        acc_next = acc_reg;
        cnt_next = cnt_reg;
        if (rd_v_reg)
        begin
            acc_next = acc_reg + SUM_W'(rd_data_reg);
            cnt_next = cnt_reg + CNT_W'(1);
        end
    end

    assign divisor   = (cnt_reg == '0) ? CNT_W'(1) : cnt_reg;
    assign rem_shift = {rem_reg[CNT_W-1:0], quo_reg[SUM_W-1]};
    assign rem_ge    = (rem_shift >= {1'b0, divisor});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            rd_v_reg  <= 1'b0;
            step_reg  <= '0;
        end
        else
        begin
            rd_v_reg <= tap_v;
            case (state_reg)
                ST_IDLE:
                begin
                    if (!q_empty)
                    begin
                        state_reg <= ST_READ;
                        step_reg  <= '0;
                    end
                end
                ST_READ:
                begin
                    step_reg <= step_reg + STEP_W'(1);
                    if (step_reg == STEP_W'(TAPS))
                        state_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    if (bit_reg == DIVB_W'(SUM_W - 1))
                        state_reg <= ST_OUT;
                end
                ST_OUT:
                begin
                    if (!out_stall)
                        state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                job_reg <= q_dout;
                acc_reg <= '0;
                cnt_reg <= '0;
            end
            ST_READ:
            begin
                acc_reg <= acc_next;
                cnt_reg <= cnt_next;
                quo_reg <= acc_next;
                rem_reg <= '0;
                bit_reg <= '0;
            end
            ST_DIV:
            begin
                rem_reg <= rem_ge ? rem_shift - {1'b0, divisor} : rem_shift;
                quo_reg <= {quo_reg[SUM_W-2:0], rem_ge};
                bit_reg <= bit_reg + DIVB_W'(1);
                if (bit_reg == DIVB_W'(SUM_W - 1))
                    val_reg <= VAL_W'({quo_reg[SUM_W-2:0], rem_ge});
            end
            default:
            begin
                val_reg <= val_reg;
            end
        endcase
    end

    assign out_valid     = (state_reg == ST_OUT);
    assign blurred_value = val_reg;
    assign out_line      = OUT_IDX_W'(job_reg.line);
    assign out_position  = OUT_IDX_W'(job_reg.pos);
    assign last_of_run   = job_reg.last;
    assign frame_done    = job_reg.fdone;

endmodule

[rtl/edge_normalized_box_blur.sv]
// Top level of the edge-normalized 4x4 box blur.
// Depends on ebb_pkg, ebb_front, ebb_queue and ebb_back.
`timescale 1ns / 1ps
//
//  channel   direction  handshake              payload
//  config    in         cfg_we                 cfg_index, cfg_data
//  samples   in         in_valid / in_stall    sample_value
//  results   out        out_valid / out_stall  blurred_value, out_line, out_position,
//                                              last_of_run, frame_done
//
// A sample is taken when in_valid is high and in_stall is low. The front then pushes its
// 0 to 4 jobs, one per cycle. Each result passes through the back in order: a pop, 16 store
// reads plus a step to add the last registered tap, 20 restoring divider steps,
// and the output state. No new sample is taken until every result of the last one has
// left the back.
// Reset clears counters and handshake state; the line store is not cleared.
// A stall on the result side holds the result and the whole block.

module edge_normalized_box_blur
    import ebb_pkg::*;
#(
    parameter int MAX_LINE  = DEF_MAX_LINE,
    parameter int MAX_LINES = DEF_MAX_LINES
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [VAL_W-1:0]     sample_value,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [VAL_W-1:0]     blurred_value,
    output logic [OUT_IDX_W-1:0] out_line,
    output logic [OUT_IDX_W-1:0] out_position,
    output logic                 last_of_run,
    output logic                 frame_done
);

    localparam int LW    = $clog2(MAX_LINES + 1);
    localparam int PW    = $clog2(MAX_LINE + 1);
    localparam int AW    = $clog2(WINDOW * MAX_LINE);
    localparam int JOB_W = LW + PW + 2;

    logic             q_push, q_pop, q_empty, q_full;
    logic [JOB_W-1:0] q_din, q_dout;
    logic             back_busy;
    logic [LW-1:0]    nl;
    logic [PW-1:0]    ll;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic [VAL_W-1:0] wr_data;

    // front: take samples, advance raster position, issue one job per cycle
    ebb_front #(
        .MAX_LINE  (MAX_LINE),
        .MAX_LINES (MAX_LINES),
        .LW        (LW),
        .PW        (PW),
        .AW        (AW),
        .JOB_W     (JOB_W)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .sample_value (sample_value),
        .q_empty      (q_empty),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_din        (q_din),
        .back_busy    (back_busy),
        .nl           (nl),
        .ll           (ll),
        .wr_en        (wr_en),
        .wr_addr      (wr_addr),
        .wr_data      (wr_data)
    );

    // hold pending jobs between front and back
    ebb_queue #(
        .W (JOB_W)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .din   (q_din),
        .pop   (q_pop),
        .dout  (q_dout),
        .empty (q_empty),
        .full  (q_full)
    );

    // back: gather the window, divide by the tap count, present the result
    ebb_back #(
        .MAX_LINE  (MAX_LINE),
        .MAX_LINES (MAX_LINES),
        .LW        (LW),
        .PW        (PW),
        .AW        (AW),
        .JOB_W     (JOB_W)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_empty       (q_empty),
        .q_dout        (q_dout),
        .q_pop         (q_pop),
        .nl            (nl),
        .ll            (ll),
        .wr_en         (wr_en),
        .wr_addr       (wr_addr),
        .wr_data       (wr_data),
        .busy          (back_busy),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .blurred_value (blurred_value),
        .out_line      (out_line),
        .out_position  (out_position),
        .last_of_run   (last_of_run),
        .frame_done    (frame_done)
    );

endmodule

[rtl/ebb_checker.sv]
// Port-level checks for the box blur, bound to the top level.
// Depends on ebb_pkg and edge_normalized_box_blur.
`timescale 1ns / 1ps

module ebb_checker
    import ebb_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 cfg_we,
    input logic [CFG_IDX_W-1:0] cfg_index,
    input logic [CFG_W-1:0]     cfg_data,
    input logic                 in_valid,
    input logic                 in_stall,
    input logic [VAL_W-1:0]     sample_value,
    input logic                 out_valid,
    input logic                 out_stall,
    input logic [VAL_W-1:0]     blurred_value,
    input logic [OUT_IDX_W-1:0] out_line,
    input logic [OUT_IDX_W-1:0] out_position,
    input logic                 last_of_run,
    input logic                 frame_done
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result request dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(blurred_value) && $stable(out_position))
        else $error("stalled result changed");

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |-> !out_valid)
        else $error("sample taken while a result is pending");

    a_frame_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_done |-> last_of_run)
        else $error("frame end not on the last result of a run");

endmodule

bind edge_normalized_box_blur ebb_checker u_ebb_checker (.*);
